// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

// ----- rtl/swmf_pkg.sv -----
`timescale 1ns / 1ps

package swmf_pkg;

   localparam int LEN_W = 5;
   localparam logic [LEN_W-1:0] LEN_RESET = 5'd5;

   typedef struct packed {
      logic write_sample;
      logic clear_idx;
      logic next_idx;
      logic load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic found;
   } dp_status_type;

endpackage

// ----- rtl/swmf_ctrl.sv -----
`timescale 1ns / 1ps

module swmf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  swmf_pkg::dp_status_type status,
   output swmf_pkg::ctrl_cmd_type  cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept, load;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid & req_ready;
   assign load      = (state_ff == ST_SCAN) & status.found & (~rsp_valid_ff | rsp_ready);

   always_comb begin
      cmd.write_sample = accept;
      cmd.clear_idx    = accept;
      cmd.next_idx     = (state_ff == ST_SCAN) & ~status.found;
      cmd.load_out     = load;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/swmf_datapath.sv -----
`timescale 1ns / 1ps

module swmf_datapath #(
   parameter int MAX_WINDOW  = 16,
   parameter int SAMPLE_BITS = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [swmf_pkg::LEN_W-1:0]  csr_window_len,
   input  logic [SAMPLE_BITS-1:0]      req_sample,
   output logic [SAMPLE_BITS-1:0]      rsp_median,
   input  swmf_pkg::ctrl_cmd_type      cmd,
   output swmf_pkg::dp_status_type     status
);

   localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CNT_W = $clog2(MAX_WINDOW + 1);
   localparam int EW    = (CNT_W > swmf_pkg::LEN_W) ? CNT_W : swmf_pkg::LEN_W;

   logic [SAMPLE_BITS-1:0]     win_ff  [MAX_WINDOW];
   logic [SAMPLE_BITS-1:0]     win_in  [MAX_WINDOW];
   logic [IDX_W-1:0]           pos_ff, pos_in;
   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic [swmf_pkg::LEN_W-1:0] len_ff, len_in;
   logic [SAMPLE_BITS-1:0]     median_ff, median_in;

   logic [EW-1:0]          len_ext, n_ext;
   logic [CNT_W-1:0]       n, k, pos_inc, below, not_above;
   logic [IDX_W-1:0]       wr_sel, pos_nx;
   logic [SAMPLE_BITS-1:0] cand;
   logic [MAX_WINDOW-1:0]  lt_vec, le_vec;

   // effective length, clamped to 1..MAX_WINDOW
   always_comb begin
      len_ext = EW'(len_ff);
      if (len_ext == '0) begin
         n_ext = EW'(1);
      end else if (len_ext > EW'(MAX_WINDOW)) begin
         n_ext = EW'(MAX_WINDOW);
      end else begin
         n_ext = len_ext;
      end
      n = n_ext[CNT_W-1:0];
      k = n >> 1;
   end

   always_comb begin
      wr_sel  = (CNT_W'(pos_ff) >= n) ? '0 : pos_ff;
      pos_inc = CNT_W'(wr_sel) + CNT_W'(1);
      pos_nx  = (pos_inc >= n) ? '0 : pos_inc[IDX_W-1:0];
   end

   // rank of the current candidate against every entry in use
   assign cand = win_ff[idx_ff];

   always_comb begin
      for (int j = 0; j < MAX_WINDOW; j++) begin
         lt_vec[j] = (CNT_W'(j) < n) && (win_ff[j] <  cand);
         le_vec[j] = (CNT_W'(j) < n) && (win_ff[j] <= cand);
      end
      below     = CNT_W'($countones(lt_vec));
      not_above = CNT_W'($countones(le_vec));
   end

   assign status.found = (below <= k) && (k < not_above);
   assign rsp_median   = median_ff;

   always_comb begin
      win_in = win_ff;
      pos_in = pos_ff;
      len_in = len_ff;
      if (csr_write_enable) begin
         len_in = csr_window_len;
         pos_in = '0;
         for (int j = 0; j < MAX_WINDOW; j++) begin
            win_in[j] = '0;
         end
      end else if (cmd.write_sample) begin
         win_in[wr_sel] = req_sample;
         pos_in         = pos_nx;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.clear_idx) begin
         idx_in = '0;
      end else if (cmd.next_idx) begin
         idx_in = idx_ff + IDX_W'(1);
      end
      median_in = cmd.load_out ? cand : median_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < MAX_WINDOW; j++) begin
            win_ff[j] <= '0;
         end
         pos_ff <= '0;
         len_ff <= swmf_pkg::LEN_RESET;
         idx_ff <= '0;
      end else begin
         win_ff <= win_in;
         pos_ff <= pos_in;
         len_ff <= len_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      median_ff <= median_in;
   end

endmodule

// ----- rtl/sliding_window_median_filter_core.sv -----
// Running median filter over a sliding window of samples.
// req_*: one sample word per handshake (req_valid/req_ready). Each word
//   replaces the oldest window entry, then the window median is searched.
// rsp_*: one median word per sample, upper middle value for even lengths.
// csr_*: csr_write_enable with csr_window_len sets the window length
//   (0 acts as 1, values above MAX_WINDOW act as MAX_WINDOW) and clears
//   the window to zeros. Write only while no sample is in flight.
// Timing: the accept cycle writes the window; then one candidate entry
//   per cycle is ranked against all entries in use by a parallel compare
//   and count unit. The scan ends at the first entry holding the median
//   rank, at position 1..length. The result is registered at the end of
//   the scan.
// A stalled result holds in the output register; the next sample may be
//   accepted and scanned meanwhile, and its scan waits at the end until
//   the output register frees up.
// Reset: window zeroed, write position 0, length 5, no result pending.
`timescale 1ns / 1ps

module sliding_window_median_filter_core #(
   parameter int MAX_WINDOW  = 16,
   parameter int SAMPLE_BITS = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [swmf_pkg::LEN_W-1:0] csr_window_len,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [SAMPLE_BITS-1:0]     req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [SAMPLE_BITS-1:0]     rsp_median
);

   swmf_pkg::ctrl_cmd_type  cmd;
   swmf_pkg::dp_status_type status;

   swmf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   swmf_datapath #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_window_len   (csr_window_len),
      .req_sample       (req_sample),
      .rsp_median       (rsp_median),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

// ----- rtl/swmf_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module swmf_checker #(
   parameter int SAMPLE_BITS = 10
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [SAMPLE_BITS-1:0] rsp_median
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_median))
   // a scan always follows an accepted word
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   // a new result only ever comes out of a scan
   `ASSERT_IMPLIES(a_rsp_from_scan, clock, reset, $rose(rsp_valid), $past(!req_ready))

endmodule

bind sliding_window_median_filter_core swmf_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_swmf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_median (rsp_median)
);
